// ===== rtl/qrs_peak_detector_core_assert.svh =====
// Assertion macros for the QRS peak detector core.
`ifndef QRS_PEAK_DETECTOR_CORE_ASSERT_SVH
`define QRS_PEAK_DETECTOR_CORE_ASSERT_SVH
// Checks that an implication holds at every rising clock edge outside reset.
`define QPD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Checks that an implication holds at the next rising clock edge, outside reset.
`define QPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/qpd_pkg.sv =====
// Package with shared constants and types of the QRS peak detector.
package qpd_pkg;
	localparam int RR_DEPTH_DEF    = 8;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF  = 20;
	localparam int RR_OUT_BITS     = 20;
	localparam int CFG_IDX_BITS    = 2;
	localparam int CFG_DATA_BITS   = 16;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_BITS-1:0] REG_FS_RATE     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOWER_GAIN  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_UPPER_GAIN  = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_INIT_LENGTH = 2'd3;

	// States of the execution engine.
	typedef enum logic [2:0] {
		EX_IDLE,
		EX_DIV,
		EX_TENTH,
		EX_MUL,
		EX_DECIDE,
		EX_DONE
	} ex_state_t;
endpackage

// ===== rtl/qpd_front.sv =====
// Front end: accepts sample words and pairs each with its predecessor.
module qpd_front
	import qpd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	output logic                          q_valid,
	input  logic                          q_ready,
	output logic signed [SAMPLE_BITS-1:0] q_cur,
	output logic signed [SAMPLE_BITS-1:0] q_prev
);
	// Two-entry queue of (current, previous) pairs toward the back end.
	logic signed [SAMPLE_BITS-1:0] cur_q [2];
	logic signed [SAMPLE_BITS-1:0] prv_q [2];
	logic signed [SAMPLE_BITS-1:0] last_q;
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_cur    = cur_q[rd_q];
	assign q_prev   = prv_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			rd_q   <= 1'b0;
			wr_q   <= 1'b0;
			last_q <= '0;
		end else begin
			if (push) begin
				last_q <= in_sample;
				wr_q   <= ~wr_q;
			end
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cur_q[wr_q] <= in_sample;
			prv_q[wr_q] <= last_q;
		end
	end
endmodule

// ===== rtl/qpd_back.sv =====
// Back end: seeding, peak classification, level tracking and RR history.
module qpd_back
	import qpd_pkg::*;
#(
	parameter int RR_DEPTH    = RR_DEPTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  logic signed [SAMPLE_BITS-1:0] q_cur,
	input  logic signed [SAMPLE_BITS-1:0] q_prev,
	input  logic [15:0]                   fs_rate,
	input  logic [11:0]                   lower_gain,
	input  logic [11:0]                   upper_gain,
	input  logic [15:0]                   init_length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          beat,
	output logic [RR_OUT_BITS-1:0]        rr_interval,
	output logic                          seeded
);
	localparam int LB  = SAMPLE_BITS + 8;
	localparam int HB  = (RR_DEPTH > 1) ? $clog2(RR_DEPTH) : 1;
	localparam int BRB = $clog2(RR_DEPTH + 1);
	localparam int SB  = COUNT_BITS + HB + 1;
	localparam int AB  = SAMPLE_BITS + 17;
	localparam int NB  = AB + 4;
	localparam int PB  = SB + 12;
	localparam int DB  = 17;
	localparam int TW  = COUNT_BITS + 18;
	localparam int MB  = SAMPLE_BITS + 4;
	localparam int RS  = MB + 3;
	localparam logic [MB-1:0] RK = MB'(((64'd1 << RS) + 64'd9) / 64'd10);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic signed [LB-1:0] LV_HI = {1'b0, {(LB-1){1'b1}}};
	localparam logic signed [LB-1:0] LV_LO = {1'b1, {(LB-1){1'b0}}};

	ex_state_t st_q, st_d;
	logic signed [LB-1:0] sig_q, noi_q;
	logic                 rising_q, pulsed_q, seeded_q;
	logic [COUNT_BITS-1:0] since_q;
	logic [BRB-1:0]        br_q;
	logic [HB-1:0]         head_q;
	logic [COUNT_BITS-1:0] hist_q [RR_DEPTH];
	logic [SB-1:0]         isum_q;
	logic signed [AB-1:0]  acc_q;
	logic [15:0]           nz_q, pos_q;
	logic signed [SAMPLE_BITS-1:0] cur_q, prv_q;
	// Divider registers.
	logic [NB-1:0]  rem_q, quo_q;
	logic [DB-1:0]  div_q;
	logic           neg_q;
	logic [5:0]     it_q;
	logic signed [LB+2:0] m_hold_q;
	// Multiplier results of the RR limits.
	logic [PB-1:0]  plo_q, phi_q;
	logic           ov_q, ob_q;
	logic [RR_OUT_BITS-1:0] orr_q;

	assign q_ready   = (st_q == EX_IDLE) && (!ov_q || out_ready);
	assign out_valid = ov_q;
	assign beat      = ob_q;
	assign rr_interval = orr_q;
	assign seeded    = seeded_q;

	function automatic logic signed [LB-1:0] sat(input logic signed [LB+2:0] v);
		if (v > (LB+3)'(LV_HI)) return LV_HI;
		if (v < (LB+3)'(LV_LO)) return LV_LO;
		return v[LB-1:0];
	endfunction

	// Combinational datapath of the decide and seeding steps.
	logic signed [LB+2:0] x16, t1, t2, esig, en8, en4;
	logic [COUNT_BITS-1:0] since_inc;
	logic [SB+11:0] scaled;
	logic [16:0] tmo;
	logic signed [NB:0] mtrunc;
	logic [NB-1:0] rem_sh;
	logic signed [LB+2:0] mq, mag_abs, tenth;
	logic [2*MB-1:0] rprod;
	logic [MB-1:0] tenth_u;

	always_comb begin
		x16  = (LB+3)'(prv_q) <<< 4;
		t1   = (LB+3)'(noi_q) + (((LB+3)'(sig_q) - (LB+3)'(noi_q)) >>> 2);
		t2   = t1 >>> 1;
		esig = (LB+3)'(sig_q) + ((x16 - (LB+3)'(sig_q)) >>> 3);
		en8  = (LB+3)'(noi_q) + ((x16 - (LB+3)'(noi_q)) >>> 3);
		en4  = (LB+3)'(noi_q) + ((x16 - (LB+3)'(noi_q)) >>> 2);
		since_inc = (since_q == CNT_MAX) ? since_q : since_q + 1'b1;
		scaled = (SB+12)'(since_q) * (SB+12)'(256 * RR_DEPTH);
		tmo    = {fs_rate, 1'b0};
		rem_sh = {rem_q[NB-2:0], quo_q[NB-1]};
		mtrunc = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		mq = (LB+3)'(mtrunc);
		// A tenth of the mean by reciprocal multiplication, truncated toward zero.
		mag_abs = m_hold_q[LB+2] ? -m_hold_q : m_hold_q;
		rprod   = (2*MB)'(MB'(mag_abs)) * (2*MB)'(RK);
		tenth_u = MB'(rprod >> RS);
		tenth   = m_hold_q[LB+2] ? -(LB+3)'(tenth_u) : (LB+3)'(tenth_u);
	end

	// Seeding window bookkeeping.
	logic seed_done, seed_go;
	logic [15:0] pos_n, nz_sum;
	logic signed [AB-1:0] acc_sum;
	assign pos_n   = pos_q + 1'b1;
	assign seed_done = (pos_n >= init_length);
	assign acc_sum = acc_q + AB'(q_cur);
	assign nz_sum  = nz_q + ((q_cur != '0) ? 16'd1 : 16'd0);
	assign seed_go = seed_done && (nz_sum != 16'd0);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= EX_IDLE;
		else st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			EX_IDLE: if (q_valid && q_ready) begin
				priority if (seeded_q) st_d = EX_MUL;
				else if (seed_go) st_d = EX_DIV;
				else st_d = EX_DONE;
			end
			EX_DIV:    if (it_q == 6'd0) st_d = EX_TENTH;
			EX_TENTH:  st_d = EX_DONE;
			EX_MUL:    st_d = EX_DECIDE;
			EX_DECIDE: st_d = EX_IDLE;
			EX_DONE:   st_d = EX_IDLE;
			default:   st_d = EX_IDLE;
		endcase
	end

	// Result valid flag: set when a word finishes, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (st_q == EX_DECIDE || st_q == EX_DONE) ov_q <= 1'b1;
		else if (out_ready) ov_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_q <= '0; noi_q <= '0; rising_q <= 1'b1; pulsed_q <= 1'b0;
			seeded_q <= 1'b0; since_q <= '0; br_q <= '0; head_q <= '0;
			isum_q <= '0; acc_q <= '0; nz_q <= '0; pos_q <= '0;
			ob_q <= 1'b0; orr_q <= '0; it_q <= '0;
			cur_q <= '0; prv_q <= '0; rem_q <= '0; quo_q <= '0; div_q <= '0;
			neg_q <= 1'b0; m_hold_q <= '0; plo_q <= '0; phi_q <= '0;
			for (int i = 0; i < RR_DEPTH; i++) hist_q[i] <= '0;
		end else begin
			unique case (st_q)
				EX_IDLE: if (q_valid && q_ready) begin
					cur_q <= q_cur;
					prv_q <= q_prev;
					ob_q  <= 1'b0;
					orr_q <= '0;
					if (!seeded_q) begin
						if (seed_done) begin
							pos_q <= '0;
							acc_q <= '0;
							nz_q  <= '0;
							if (seed_go) begin
								// Start the seed mean division.
								neg_q <= acc_sum[AB-1];
								quo_q <= NB'(acc_sum[AB-1] ? -acc_sum : acc_sum) << 4;
								rem_q <= '0;
								div_q <= {1'b0, nz_sum};
								it_q  <= 6'(NB);
							end else begin
								sig_q <= '0; noi_q <= '0;
							end
						end else begin
							pos_q <= pos_n;
							acc_q <= acc_sum;
							nz_q  <= nz_sum;
						end
					end
				end
				EX_DIV: begin
					if (it_q != 0) begin
						if (rem_sh >= NB'(div_q)) begin
							rem_q <= rem_sh - NB'(div_q);
							quo_q <= {quo_q[NB-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[NB-2:0], 1'b0};
						end
						it_q <= it_q - 1'b1;
					end else begin
						m_hold_q <= mq;
					end
				end
				EX_TENTH: begin
					// Levels sit a tenth above and below the mean.
					sig_q <= sat(m_hold_q + tenth);
					noi_q <= sat(m_hold_q - tenth);
					rising_q <= 1'b1;
					seeded_q <= 1'b1;
				end
				EX_MUL: begin
					plo_q <= PB'(lower_gain) * PB'(isum_q);
					phi_q <= PB'(upper_gain) * PB'(isum_q);
				end
				EX_DECIDE: begin
					if (rising_q && prv_q > cur_q) begin
						rising_q <= 1'b0;
						if (x16 >= t1 || TW'(since_q) > TW'(tmo)) begin
							if (32'(br_q) < RR_DEPTH) begin
								// Warm-up: fill the history, then count this word.
								hist_q[br_q[HB-1:0]] <= since_q;
								br_q <= br_q + 1'b1;
								isum_q <= isum_q + SB'(since_q);
								since_q <= COUNT_BITS'(1);
							end else begin
								pulsed_q <= 1'b1;
								if (plo_q <= scaled) begin
									isum_q <= isum_q + SB'(since_q) - SB'(hist_q[head_q]);
									hist_q[head_q] <= since_q;
									head_q <= (32'(head_q) == RR_DEPTH - 1) ? '0
										: head_q + 1'b1;
									ob_q <= 1'b1; orr_q <= RR_OUT_BITS'(since_q);
									since_q <= '0;
								end else begin
									since_q <= since_inc;
								end
							end
							sig_q <= sat(esig);
						end else if (pulsed_q && scaled >= phi_q && x16 >= t2) begin
							noi_q <= sat(en4);
							ob_q <= 1'b1; orr_q <= RR_OUT_BITS'(since_q);
							since_q <= '0;
						end else begin
							noi_q <= sat(en8);
							since_q <= since_inc;
						end
					end else begin
						if (prv_q <= cur_q) rising_q <= 1'b1;
						since_q <= since_inc;
					end
				end
				EX_DONE: ;
				default: ;
			endcase
		end
	end
endmodule

// ===== rtl/qrs_peak_detector_core.sv =====
// Top level of the QRS peak detector: configuration, front end and back end.
//  channel | direction | handshake
//  in      | input     | in_valid / in_ready, sample
//  out     | output    | out_valid / out_ready, beat, rr_interval, seeded
//  cfg     | input     | cfg_valid / cfg_ready, cfg_index, cfg_data
// A seeding word is accepted and finished with no further steps; the window's
// last word runs a restoring divider for the mean if any word was nonzero.
// A detection word passes accept, gain multiply and decision steps.
// A finished word may leave in the cycle the next one is taken. Reset returns
// all levels to zero. A stalled output holds the back end; the front queue
// keeps two more words.
module qrs_peak_detector_core
	import qpd_pkg::*;
#(
	parameter int RR_DEPTH    = RR_DEPTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          beat,
	output logic [RR_OUT_BITS-1:0]        rr_interval,
	output logic                          seeded,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data
);
	`include "qrs_peak_detector_core_assert.svh"

	logic [15:0] rate_q, len_q;
	logic [11:0] lg_q, ug_q;
	logic q_valid, q_ready;
	logic signed [SAMPLE_BITS-1:0] q_cur, q_prev;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= 16'd250; lg_q <= 12'd128; ug_q <= 12'd426; len_q <= 16'd250;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FS_RATE:     rate_q <= cfg_data;
				REG_LOWER_GAIN:  lg_q   <= cfg_data[11:0];
				REG_UPPER_GAIN:  ug_q   <= cfg_data[11:0];
				REG_INIT_LENGTH: len_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	qpd_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_sample(sample),
		.q_valid, .q_ready, .q_cur, .q_prev
	);

	qpd_back #(.RR_DEPTH(RR_DEPTH), .SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS(COUNT_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_cur, .q_prev,
		.fs_rate(rate_q), .lower_gain(lg_q), .upper_gain(ug_q),
		.init_length(len_q), .out_valid, .out_ready, .beat, .rr_interval, .seeded
	);

	// A beat is never reported before seeding completes.
	`QPD_ASSERT_IMP(a_beat_seeded, out_valid && beat, seeded)
	// Seeding, once done, stays done.
	`QPD_ASSERT_NEXT(a_seed_sticky, seeded, seeded)
	// A pending word holds while the output is stalled.
	`QPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(beat))
endmodule
